// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Each macro uses the block clock and its synchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, sequencer states and saturation helpers for the PID
// rate controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prc_pkg;

   localparam int VALUE_W    = 32;
   localparam int GAIN_W     = 31;
   localparam int STEP_W     = 24;
   localparam int FRAC_BITS  = 16;
   localparam int TIME_FRAC  = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 33;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

   localparam logic [STEP_W-1:0] DERIV_MIN_DT = STEP_W'(16);

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_RC   = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ERR, ST_MP, ST_MI, ST_MI2, ST_MI3, ST_MI4, ST_MD, ST_MD2,
      ST_DV, ST_DVW, ST_SUM, ST_RAW, ST_FM, ST_FMUL, ST_FD, ST_FDW, ST_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   // Saturate a 34-bit signed sum to the value range.
   function automatic logic signed [VALUE_W-1:0] sat_wide(logic signed [33:0] v);
      logic signed [33:0] vmax;
      logic signed [33:0] vmin;
      vmax = 34'sh0_7FFF_FFFF;
      vmin = -34'sh0_8000_0000;
      if (v > vmax) return 32'sh7FFF_FFFF;
      if (v < vmin) return 32'sh8000_0000;
      return v[VALUE_W-1:0];
   endfunction

   // Apply a sign to a magnitude, capping it to the signed range.
   function automatic logic signed [VALUE_W-1:0] sat_mag(logic [63:0] m, logic neg);
      logic [63:0] cap;
      logic [63:0] r;
      cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      r   = (m > cap) ? cap : m;
      return neg ? -r[VALUE_W-1:0] : r[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] mag(logic signed [VALUE_W-1:0] v);
      return v[VALUE_W-1] ? -v : v;
   endfunction

   function automatic logic signed [VALUE_W-1:0] clamp_sym(logic signed [VALUE_W-1:0] v,
                                                           logic [GAIN_W-1:0] lim);
      logic signed [VALUE_W-1:0] l;
      l = $signed({1'b0, lim});
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
   endfunction

   function automatic logic signed [33:0] sext34(logic signed [VALUE_W-1:0] v);
      return {{2{v[VALUE_W-1]}}, v};
   endfunction

endpackage

// ----- rtl/pid_rate_controller_antiwindup.sv -----
// ----------------------------------------------------------------------------
// pid_rate_controller_antiwindup
// PID rate controller with conditional-integration anti-windup and an
// optional first-order output low-pass, built around one shared multiplier
// and one shared divider under a sequencer.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  op, setpoint, sensed, feedfwd, step_time
//   rsp_      out        rsp_valid / rsp_ready  drive, integ_held
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A clear request goes from idle straight to the output state. An update
// steps through the error, multiply and sum states, plus one division for
// each in use: the derivative division when step_time is above 16, the filter
// division when filter_rc is nonzero, each run on the shared 64-step serial
// divider. Both wait in the output state until the output register is free.
// Reset (synchronous) zeros the configuration, integral, history, rsp_valid and the controller state.
// req_ready is high only while the sequencer is idle; a finished response
// waits in the output register and the next request is taken meanwhile.
// csr_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pid_rate_controller_antiwindup import prc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic signed [VALUE_W-1:0] req_setpoint,
   input  logic signed [VALUE_W-1:0] req_sensed,
   input  logic signed [VALUE_W-1:0] req_feedfwd,
   input  logic [STEP_W-1:0]         req_step_time,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_drive,
   output logic                      rsp_integ_held,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [VALUE_W-1:0]        csr_wdata
);

   // configuration
   logic [GAIN_W-1:0]  prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [GAIN_W-1:0]  out_limit_ff, integ_limit_ff;
   logic [VALUE_W-1:0] filter_rc_ff;

   // control and controller state
   state_type                 state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] integ_acc_ff, integ_acc_in;
   logic signed [VALUE_W-1:0] prev_sensed_ff, prev_sensed_in;
   logic signed [VALUE_W-1:0] prev_drive_ff, prev_drive_in;

   // request payload and working registers
   logic                      op_ff, op_in;
   logic signed [VALUE_W-1:0] sp_ff, sp_in, ms_ff, ms_in, feedfwd_ff, feedfwd_in;
   logic [STEP_W-1:0]         dt_ff, dt_in;
   logic signed [VALUE_W-1:0] err_ff, err_in, dp_ff, dp_in;
   logic signed [VALUE_W-1:0] pterm_ff, pterm_in, tmp_ff, tmp_in;
   logic signed [VALUE_W-1:0] cand_ff, cand_in, deriv_ff, deriv_in;
   logic signed [VALUE_W-1:0] raw_ff, raw_in, res_ff, res_in;
   logic                      held_ff, held_in;
   logic [VALUE_W-1:0]        fmag_ff, fmag_in;
   logic                      fneg_ff, fneg_in;
   logic signed [VALUE_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                      rsp_held_ff, rsp_held_in;

   // shared units
   logic [VALUE_W-1:0] mul_a, mul_b;
   logic               mul_neg;
   logic [PROD_W-1:0]  prod;
   logic               prod_neg;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic                      req_take;
   logic signed [33:0]        sum;
   logic signed [VALUE_W-1:0] cout;
   logic signed [VALUE_W:0]   diff;
   logic [VALUE_W:0]          dmag;
   logic signed [VALUE_W:0]   olim;

   prc_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_neg  (mul_neg),
      .prod     (prod),
      .prod_neg (prod_neg)
   );

   prc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign olim      = $signed({2'b00, out_limit_ff});

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      integ_acc_in   = integ_acc_ff;
      prev_sensed_in = prev_sensed_ff;
      prev_drive_in  = prev_drive_ff;
      op_in          = op_ff;
      sp_in          = sp_ff;
      ms_in          = ms_ff;
      feedfwd_in     = feedfwd_ff;
      dt_in          = dt_ff;
      err_in         = err_ff;
      dp_in          = dp_ff;
      pterm_in       = pterm_ff;
      tmp_in         = tmp_ff;
      cand_in        = cand_ff;
      deriv_in       = deriv_ff;
      raw_in         = raw_ff;
      res_in         = res_ff;
      held_in        = held_ff;
      fmag_in        = fmag_ff;
      fneg_in        = fneg_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_held_in    = rsp_held_ff;
      mul_a          = '0;
      mul_b          = '0;
      mul_neg        = 1'b0;
      div_req        = '0;
      sum            = '0;
      cout           = '0;
      diff           = '0;
      dmag           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in      = req_op;
               sp_in      = req_setpoint;
               ms_in      = req_sensed;
               feedfwd_in = req_feedfwd;
               dt_in      = req_step_time;
               if (req_op) begin
                  // clear: drop all history, answer zero
                  integ_acc_in   = '0;
                  prev_sensed_in = '0;
                  prev_drive_in  = '0;
                  res_in         = '0;
                  held_in        = 1'b0;
                  state_in       = ST_OUT;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            err_in   = sat_wide(sext34(sp_ff) - sext34(ms_ff));
            dp_in    = sat_wide(sext34(prev_sensed_ff) - sext34(ms_ff));
            deriv_in = '0;
            state_in = ST_MP;
         end
         ST_MP: begin
            mul_a    = mag(err_ff);
            mul_b    = {1'b0, prop_gain_ff};
            mul_neg  = err_ff[VALUE_W-1];
            state_in = ST_MI;
         end
         ST_MI: begin
            pterm_in = sat_mag(prod >> FRAC_BITS, prod_neg);
            mul_a    = mag(err_ff);
            mul_b    = {1'b0, integ_gain_ff};
            mul_neg  = err_ff[VALUE_W-1];
            state_in = ST_MI2;
         end
         ST_MI2: begin
            tmp_in   = sat_mag(prod >> FRAC_BITS, prod_neg);
            state_in = ST_MI3;
         end
         ST_MI3: begin
            mul_a    = mag(tmp_ff);
            mul_b    = {{(VALUE_W-STEP_W){1'b0}}, dt_ff};
            mul_neg  = tmp_ff[VALUE_W-1];
            state_in = ST_MI4;
         end
         ST_MI4: begin
            // candidate integral, clamped to the integral limit
            cand_in  = clamp_sym(sat_wide(sext34(integ_acc_ff)
                                 + sext34(sat_mag(prod >> TIME_FRAC, prod_neg))),
                                 integ_limit_ff);
            state_in = (dt_ff > DERIV_MIN_DT) ? ST_MD : ST_SUM;
         end
         ST_MD: begin
            mul_a    = mag(dp_ff);
            mul_b    = {1'b0, deriv_gain_ff};
            mul_neg  = dp_ff[VALUE_W-1];
            state_in = ST_MD2;
         end
         ST_MD2: begin
            tmp_in   = sat_mag(prod >> FRAC_BITS, prod_neg);
            state_in = ST_DV;
         end
         ST_DV: begin
            // derivative = p * 2^24 / dt on the magnitude
            div_req.start    = 1'b1;
            div_req.dividend = {8'd0, mag(tmp_ff), 24'd0};
            div_req.divisor  = {{(DIV_DEN_W-STEP_W){1'b0}}, dt_ff};
            state_in         = ST_DVW;
         end
         ST_DVW: begin
            if (div_rsp.done) begin
               deriv_in = sat_mag(div_rsp.quot, tmp_ff[VALUE_W-1]);
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum  = sext34(pterm_ff) + sext34(cand_ff) + sext34(deriv_ff)
                   + sext34(feedfwd_ff);
            cout = sat_wide(sum);
            // keep the candidate only strictly inside the output limit
            if ((sext34(cout) < sext34(olim[VALUE_W-1:0]))
                && (sext34(cout) > -sext34(olim[VALUE_W-1:0]))) begin
               integ_acc_in = cand_ff;
               held_in      = 1'b0;
            end else begin
               held_in = 1'b1;
            end
            state_in = ST_RAW;
         end
         ST_RAW: begin
            sum    = sext34(pterm_ff) + sext34(integ_acc_ff) + sext34(deriv_ff)
                     + sext34(feedfwd_ff);
            raw_in = clamp_sym(sat_wide(sum), out_limit_ff);
            if (filter_rc_ff == '0) begin
               res_in   = raw_in;
               state_in = ST_OUT;
            end else begin
               state_in = ST_FM;
            end
         end
         ST_FM: begin
            diff    = {prev_drive_ff[VALUE_W-1], prev_drive_ff}
                      - {raw_ff[VALUE_W-1], raw_ff};
            fneg_in = diff[VALUE_W];
            dmag    = diff[VALUE_W] ? -diff : diff;
            fmag_in = dmag[VALUE_W] ? {VALUE_W{1'b1}} : dmag[VALUE_W-1:0];
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            mul_a    = fmag_ff;
            mul_b    = filter_rc_ff;
            state_in = ST_FD;
         end
         ST_FD: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod;
            div_req.divisor  = {1'b0, filter_rc_ff}
                               + {{(DIV_DEN_W-STEP_W){1'b0}}, dt_ff};
            state_in         = ST_FDW;
         end
         ST_FDW: begin
            if (div_rsp.done) begin
               // quotient never exceeds the 32-bit magnitude
               if (fneg_ff) begin
                  sum = sext34(raw_ff) - $signed({2'b00, div_rsp.quot[VALUE_W-1:0]});
               end else begin
                  sum = sext34(raw_ff) + $signed({2'b00, div_rsp.quot[VALUE_W-1:0]});
               end
               res_in   = sat_wide(sum);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = res_ff;
               rsp_held_in  = held_ff;
               if (!op_ff) begin
                  prev_sensed_in = ms_ff;
                  prev_drive_in  = res_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         integ_acc_ff   <= '0;
         prev_sensed_ff <= '0;
         prev_drive_ff  <= '0;
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         out_limit_ff   <= '0;
         integ_limit_ff <= '0;
         filter_rc_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         integ_acc_ff   <= integ_acc_in;
         prev_sensed_ff <= prev_sensed_in;
         prev_drive_ff  <= prev_drive_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PROP_GAIN:   prop_gain_ff   <= csr_wdata[GAIN_W-1:0];
               REG_INTEG_GAIN:  integ_gain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_OUT_LIMIT:   out_limit_ff   <= csr_wdata[GAIN_W-1:0];
               REG_INTEG_LIMIT: integ_limit_ff <= csr_wdata[GAIN_W-1:0];
               REG_FILTER_RC:   filter_rc_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      op_ff        <= op_in;
      sp_ff        <= sp_in;
      ms_ff        <= ms_in;
      feedfwd_ff   <= feedfwd_in;
      dt_ff        <= dt_in;
      err_ff       <= err_in;
      dp_ff        <= dp_in;
      pterm_ff     <= pterm_in;
      tmp_ff       <= tmp_in;
      cand_ff      <= cand_in;
      deriv_ff     <= deriv_in;
      raw_ff       <= raw_in;
      res_ff       <= res_in;
      held_ff      <= held_in;
      fmag_ff      <= fmag_in;
      fneg_ff      <= fneg_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_held_ff  <= rsp_held_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive      = rsp_drive_ff;
   assign rsp_integ_held = rsp_held_ff;

   // the integral moves only at the windup decision or on a clear
   `ASSERT_NEXT(a_integ_stable, (state_ff != ST_SUM) && !(req_take && req_op), $stable(integ_acc_ff))
   // never restart the divider while it is working
   `ASSERT_IMPL(a_div_idle_start, div_req.start, !div_rsp.busy)
   // a response appears only after the sequencer has finished
   `ASSERT_IMPL(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff == ST_OUT))

endmodule

// ----- rtl/prc_mul.sv -----
// ----------------------------------------------------------------------------
// prc_mul
// Shared unsigned 32x32 multiplier with a registered product and sign tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prc_mul import prc_pkg::*; (
   input  logic               clock,
   input  logic [VALUE_W-1:0] mul_a,
   input  logic [VALUE_W-1:0] mul_b,
   input  logic               mul_neg,
   output logic [PROD_W-1:0]  prod,
   output logic               prod_neg
);

   logic [PROD_W-1:0] prod_ff;
   logic              neg_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      neg_ff  <= mul_neg;
   end

   assign prod     = prod_ff;
   assign prod_neg = neg_ff;

endmodule

// ----- rtl/prc_div.sv -----
// ----------------------------------------------------------------------------
// prc_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prc_div import prc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;

   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when the divisor fits
         rem_in = fits ? shifted - {1'b0, den_ff} : shifted;
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule
